// ===== rtl/crd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crd_pkg
// Shared types and codes for the compact record decoder.
// ----------------------------------------------------------------------------
package crd_pkg;

    // decoder phase
    localparam logic [1:0] PH_COUNT   = 2'd0;
    localparam logic [1:0] PH_HEADER  = 2'd1;
    localparam logic [1:0] PH_PAYLOAD = 2'd2;

    // field kind held while a field is in progress
    localparam logic [1:0] FK_STR = 2'd0;
    localparam logic [1:0] FK_UNS = 2'd1;
    localparam logic [1:0] FK_SGN = 2'd2;

    // result kind
    localparam logic [2:0] K_COUNT = 3'd0;
    localparam logic [2:0] K_CHAR  = 3'd1;
    localparam logic [2:0] K_EMPTY = 3'd2;
    localparam logic [2:0] K_UNS   = 3'd3;
    localparam logic [2:0] K_SGN   = 3'd4;

    typedef struct packed {
        logic [1:0]  phase;
        logic [7:0]  records_left;
        logic [5:0]  bytes_left;
        logic [1:0]  field_kind;
        logic [5:0]  field_len;
        logic        last_mark;
        logic [31:0] acc;
    } t_state;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] value;
        logic [5:0]  field_length;
        logic        field_done;
        logic        record_done;
        logic        stream_done;
        logic        too_long;
    } t_result;

endpackage
`default_nettype wire

// ===== rtl/compact_record_decoder_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// compact_record_decoder_core
// Decodes a compact record stream, one byte per transfer, into count,
// character, empty-field and integer results.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+------------------------------
//  in       | input     | i_in_valid/o_in_ready  | i_in_byte
//  out      | output    | o_out_valid/i_out_ready| o_kind, o_value, o_field_length,
//           |           |                        | o_field_done, o_record_done,
//           |           |                        | o_stream_done, o_too_long
//
//  One byte per cycle while the output is not stalled; a byte's result passes
//  through the input register, then is decoded into the result register.
//  Bytes that give no result advance the state without touching the output.
//  A stalled output holds the result register; the input register then holds
//  a byte that gives a result, and o_in_ready drops until it can move on.
//  Reset (synchronous, active low) returns to awaiting a record count.
// ----------------------------------------------------------------------------
module compact_record_decoder_core #(
    parameter int MAX_INT_BYTES = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_in_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [2:0]       o_kind,
    output logic [31:0]      o_value,
    output logic [5:0]       o_field_length,
    output logic             o_field_done,
    output logic             o_record_done,
    output logic             o_stream_done,
    output logic             o_too_long
);
    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    crd_pkg::t_state  r_state;
    crd_pkg::t_state  n_state;
    crd_pkg::t_result n_result;
    crd_pkg::t_result r_result;
    logic             r_out_valid;
    logic             has_result;
    logic             out_free;
    logic             advance;

    crd_step #(
        .MAX_INT_BYTES(MAX_INT_BYTES)
    ) u_step (
        .i_state      (r_state),
        .i_byte       (r_in_byte),
        .o_state      (n_state),
        .o_result     (n_result),
        .o_has_result (has_result)
    );

    assign out_free   = !r_out_valid || i_out_ready;
    assign advance    = r_in_valid && (!has_result || out_free);
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid           <= 1'b0;
            r_out_valid          <= 1'b0;
            r_state.phase        <= crd_pkg::PH_COUNT;
            r_state.records_left <= '0;
            r_state.bytes_left   <= '0;
            r_state.field_kind   <= crd_pkg::FK_STR;
            r_state.field_len    <= '0;
            r_state.last_mark    <= 1'b0;
            r_state.acc          <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_state <= n_state;
            end
            // drop the result on transfer, load a new one when decoded
            if (advance && has_result) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_in_byte;
        end
        if (advance && has_result) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_kind         = r_result.kind;
    assign o_value        = r_result.value;
    assign o_field_length = r_result.field_length;
    assign o_field_done   = r_result.field_done;
    assign o_record_done  = r_result.record_done;
    assign o_stream_done  = r_result.stream_done;
    assign o_too_long     = r_result.too_long;

`ifndef SYNTHESIS
    a_payload_has_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.phase == crd_pkg::PH_PAYLOAD |-> r_state.bytes_left != 6'd0)
        else $error("payload phase with no bytes left");

    a_record_needs_field: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_record_done |-> o_field_done)
        else $error("record done without field done");

    a_stream_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_stream_done |-> (o_record_done || o_kind == crd_pkg::K_COUNT))
        else $error("stream done outside a record end or count");

    a_too_long_int: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_too_long |-> (o_kind == crd_pkg::K_UNS ||
                                       o_kind == crd_pkg::K_SGN))
        else $error("too_long on a non-integer result");
`endif

endmodule
`default_nettype wire

// ===== rtl/crd_int_fmt.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crd_int_fmt
// Trims a gathered integer to its kept bytes, sign-extends it when signed (zero-extends otherwise) and flags too_long.
// ----------------------------------------------------------------------------
module crd_int_fmt #(
    parameter int MAX_INT_BYTES = 4
) (
    input  wire logic [31:0] i_acc,
    input  wire logic [5:0]  i_len,
    input  wire logic        i_signed,
    output logic [31:0]      o_value,
    output logic             o_too_long
);
    localparam int          KEEP  = (MAX_INT_BYTES < 4) ? MAX_INT_BYTES : 4;
    localparam logic [5:0]  KEEP6 = 6'(KEEP);
    localparam logic [5:0]  MAX6  = 6'(MAX_INT_BYTES);

    logic [2:0] eff;

    always_comb begin
        eff = (i_len < KEEP6) ? i_len[2:0] : KEEP6[2:0];
        unique case (eff)
            3'd0: o_value = '0;
            3'd1: o_value = {{24{i_signed & i_acc[7]}}, i_acc[7:0]};
            3'd2: o_value = {{16{i_signed & i_acc[15]}}, i_acc[15:0]};
            3'd3: o_value = {{8{i_signed & i_acc[23]}}, i_acc[23:0]};
            default: o_value = i_acc;
        endcase
        o_too_long = (i_len > MAX6);
    end

endmodule
`default_nettype wire

// ===== rtl/crd_step.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crd_step
// One byte of decode: next state and the result the byte causes, if any.
// ----------------------------------------------------------------------------
module crd_step #(
    parameter int MAX_INT_BYTES = 4
) (
    input  wire crd_pkg::t_state  i_state,
    input  wire logic [7:0]       i_byte,
    output crd_pkg::t_state       o_state,
    output crd_pkg::t_result      o_result,
    output logic                  o_has_result
);
    crd_pkg::t_state nx;
    logic [31:0]     int_value;
    logic            int_too_long;
    logic            fin;
    logic [2:0]      fin_kind;
    logic [31:0]     fin_value;
    logic            fin_tl;
    logic [7:0]      rec_dec;

    // formatting sees the accumulator with this payload byte shifted in
    crd_int_fmt #(
        .MAX_INT_BYTES(MAX_INT_BYTES)
    ) u_int_fmt (
        .i_acc      ({i_state.acc[23:0], i_byte}),
        .i_len      (i_state.field_len),
        .i_signed   (i_state.field_kind == crd_pkg::FK_SGN),
        .o_value    (int_value),
        .o_too_long (int_too_long)
    );

    always_comb begin
        nx           = i_state;
        o_result     = '0;
        o_has_result = 1'b0;
        fin          = 1'b0;
        fin_kind     = crd_pkg::K_EMPTY;
        fin_value    = '0;
        fin_tl       = 1'b0;
        rec_dec      = i_state.records_left - 8'd1;

        unique case (i_state.phase)
            crd_pkg::PH_HEADER: begin
                nx.last_mark = i_byte[7];
                nx.acc       = '0;
                if (i_byte[6]) begin
                    nx.field_kind = crd_pkg::FK_STR;
                    nx.field_len  = i_byte[5:0];
                end else begin
                    nx.field_kind = i_byte[5] ? crd_pkg::FK_SGN : crd_pkg::FK_UNS;
                    nx.field_len  = {1'b0, i_byte[4:0]};
                end
                nx.bytes_left = nx.field_len;
                if (nx.field_len == 6'd0) begin
                    // zero-length field: value stays zero, never too long
                    fin = 1'b1;
                    if (nx.field_kind == crd_pkg::FK_STR) begin
                        fin_kind = crd_pkg::K_EMPTY;
                    end else begin
                        fin_kind  = (nx.field_kind == crd_pkg::FK_SGN) ?
                                    crd_pkg::K_SGN : crd_pkg::K_UNS;
                    end
                end else begin
                    nx.phase = crd_pkg::PH_PAYLOAD;
                end
            end
            crd_pkg::PH_PAYLOAD: begin
                nx.bytes_left = i_state.bytes_left - 6'd1;
                if (i_state.field_kind == crd_pkg::FK_STR) begin
                    if (nx.bytes_left == 6'd0) begin
                        fin       = 1'b1;
                        fin_kind  = crd_pkg::K_CHAR;
                        fin_value = {24'd0, i_byte};
                    end else begin
                        o_has_result          = 1'b1;
                        o_result.kind         = crd_pkg::K_CHAR;
                        o_result.value        = {24'd0, i_byte};
                        o_result.field_length = i_state.field_len;
                    end
                end else begin
                    nx.acc = {i_state.acc[23:0], i_byte};
                    if (nx.bytes_left == 6'd0) begin
                        fin       = 1'b1;
                        fin_kind  = (i_state.field_kind == crd_pkg::FK_SGN) ?
                                    crd_pkg::K_SGN : crd_pkg::K_UNS;
                        fin_value = int_value;
                        fin_tl    = int_too_long;
                    end
                end
            end
            default: begin
                // record count, also any unused phase code
                nx.records_left = i_byte;
                o_has_result    = 1'b1;
                o_result.kind   = crd_pkg::K_COUNT;
                if (i_byte == 8'd0) begin
                    nx.phase             = crd_pkg::PH_COUNT;
                    o_result.stream_done = 1'b1;
                end else begin
                    nx.phase       = crd_pkg::PH_HEADER;
                    o_result.value = {24'd0, i_byte};
                end
            end
        endcase

        // close the field; the last field of a record counts the record down
        if (fin) begin
            o_has_result          = 1'b1;
            nx.phase              = crd_pkg::PH_HEADER;
            o_result.kind         = fin_kind;
            o_result.value        = fin_value;
            o_result.field_length = nx.field_len;
            o_result.field_done   = 1'b1;
            o_result.record_done  = nx.last_mark;
            o_result.too_long     = fin_tl;
            if (nx.last_mark) begin
                nx.records_left = rec_dec;
                if (rec_dec == 8'd0) begin
                    o_result.stream_done = 1'b1;
                    nx.phase             = crd_pkg::PH_COUNT;
                end
            end
        end

        o_state = nx;
    end

endmodule
`default_nettype wire
